/* sv/btpm_pkg.sv */
package btpm_pkg;

	localparam int NODE_COUNT = 4096;
	localparam int IDX_W = $clog2(NODE_COUNT);
	localparam int FREE_W = IDX_W + 1;
	localparam int DOM_W = 16;
	localparam int ADDR_W = 32;
	localparam int LEN_W = 6;
	localparam logic [LEN_W-1:0] LEVELS = LEN_W'(ADDR_W);
	localparam logic [FREE_W-1:0] POOL_END = FREE_W'(NODE_COUNT);

	localparam logic [1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [1:0] FUNC_ADD = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_LEN = 2'd1;
	localparam logic [1:0] ST_POOL_FULL = 2'd2;

	typedef struct packed {
		logic is_prefix;
		logic [DOM_W-1:0] domain;
		logic [1:0][IDX_W-1:0] child;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	localparam node_t EMPTY_NODE = '{is_prefix: 1'b0, domain: '0, child: '0};
	localparam node_t FRESH_NODE = '{is_prefix: 1'b0, domain: '1, child: '0};

	typedef struct packed {
		logic valid;
		logic [DOM_W-1:0] domain;
		logic matched;
		logic [1:0] status;
	} result_t;

endpackage

/* sv/btpm_ram.sv */
module btpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/btpm_walk.sv */
module btpm_walk (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           func,
	input  logic [btpm_pkg::ADDR_W-1:0]          address,
	input  logic [btpm_pkg::LEN_W-1:0]           prefix_len,
	input  logic [btpm_pkg::DOM_W-1:0]           domain_in,
	input  logic [btpm_pkg::DOM_W-1:0]           no_match,
	output btpm_pkg::result_t                    result,
	output logic                                 ram_we,
	output logic [btpm_pkg::IDX_W-1:0]           ram_waddr,
	output btpm_pkg::node_t                      ram_wdata,
	output logic [btpm_pkg::IDX_W-1:0]           ram_raddr,
	input  btpm_pkg::node_t                      ram_rdata
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_ADD = 2'd2;

	// Where the node under the walk comes from.
	localparam logic [1:0] SRC_ROOT = 2'd0;
	localparam logic [1:0] SRC_RAM = 2'd1;
	localparam logic [1:0] SRC_FRESH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] src_q;
	logic [btpm_pkg::LEN_W-1:0] lvl_q;
	logic [btpm_pkg::LEN_W-1:0] len_q;
	logic [btpm_pkg::ADDR_W-1:0] addr_q;
	logic [btpm_pkg::DOM_W-1:0] dom_q;
	logic [btpm_pkg::IDX_W-1:0] cur_q;
	logic [btpm_pkg::FREE_W-1:0] free_q;
	logic [btpm_pkg::DOM_W-1:0] best_q;
	logic hit_q;
	btpm_pkg::node_t root_q;
	btpm_pkg::result_t res_q;

	btpm_pkg::node_t node;
	btpm_pkg::node_t wnode;
	logic bit_sel;
	logic [btpm_pkg::IDX_W-1:0] nxt;
	logic nxt_none;
	logic pool_full;
	logic at_len;
	logic at_depth;
	logic hit_now;
	logic hit_n;
	logic [btpm_pkg::DOM_W-1:0] best_n;
	logic wr_cur;

	assign busy = (state_q != S_IDLE);
	assign result = res_q;

	always_comb begin
		case (src_q)
			SRC_ROOT:  node = root_q;
			SRC_RAM:   node = ram_rdata;
			default:   node = btpm_pkg::FRESH_NODE;
		endcase
		bit_sel = addr_q[btpm_pkg::ADDR_W-1];
		nxt = node.child[bit_sel];
		nxt_none = (nxt == '0);
		pool_full = (free_q == btpm_pkg::POOL_END);
		at_len = (lvl_q == len_q);
		at_depth = (lvl_q == btpm_pkg::LEVELS);
		hit_now = (src_q != SRC_ROOT) && node.is_prefix;
		best_n = hit_now ? node.domain : best_q;
		hit_n = hit_q | hit_now;

		// An add writes back at most the node it stands on, so one write port suffices.
		wnode = node;
		wr_cur = 1'b0;
		if (state_q == S_ADD) begin
			if (at_len) begin
				wnode.is_prefix = 1'b1;
				wnode.domain = dom_q;
				wr_cur = 1'b1;
			end else if (nxt_none) begin
				wr_cur = 1'b1;
				if (!pool_full) begin
					wnode.child[bit_sel] = free_q[btpm_pkg::IDX_W-1:0];
				end
			end
		end

		ram_we = wr_cur && (src_q != SRC_ROOT);
		ram_waddr = cur_q;
		ram_wdata = wnode;
		ram_raddr = nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			src_q <= SRC_ROOT;
			lvl_q <= '0;
			len_q <= '0;
			addr_q <= '0;
			dom_q <= '0;
			cur_q <= '0;
			free_q <= btpm_pkg::FREE_W'(1);
			best_q <= '0;
			hit_q <= 1'b0;
			root_q <= btpm_pkg::EMPTY_NODE;
			res_q <= '0;
		end else begin
			res_q.valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						src_q <= SRC_ROOT;
						lvl_q <= '0;
						cur_q <= '0;
						addr_q <= address;
						len_q <= prefix_len;
						dom_q <= domain_in;
						best_q <= no_match;
						hit_q <= 1'b0;
						case (func)
							btpm_pkg::FUNC_LOOKUP: begin
								state_q <= S_LOOK;
							end
							btpm_pkg::FUNC_ADD: begin
								if (prefix_len inside {[6'd1:6'd32]}) begin
									state_q <= S_ADD;
								end else begin
									res_q <= '{valid: 1'b1, domain: '0, matched: 1'b0,
										status: btpm_pkg::ST_BAD_LEN};
								end
							end
							btpm_pkg::FUNC_CLEAR: begin
								root_q <= btpm_pkg::EMPTY_NODE;
								free_q <= btpm_pkg::FREE_W'(1);
								res_q <= '{valid: 1'b1, domain: '0, matched: 1'b0,
									status: btpm_pkg::ST_OK};
							end
							default: begin
								res_q <= '{valid: 1'b1, domain: '0, matched: 1'b0,
									status: btpm_pkg::ST_OK};
							end
						endcase
					end
				end
				S_LOOK: begin
					best_q <= best_n;
					hit_q <= hit_n;
					if (at_depth || nxt_none) begin
						state_q <= S_IDLE;
						res_q <= '{valid: 1'b1, domain: best_n, matched: hit_n,
							status: btpm_pkg::ST_OK};
					end else begin
						src_q <= SRC_RAM;
						lvl_q <= lvl_q + 1'b1;
						addr_q <= addr_q << 1;
					end
				end
				S_ADD: begin
					if (wr_cur && (src_q == SRC_ROOT)) begin
						root_q <= wnode;
					end
					if (at_len) begin
						state_q <= S_IDLE;
						res_q <= '{valid: 1'b1, domain: '0, matched: 1'b0,
							status: btpm_pkg::ST_OK};
					end else if (!nxt_none) begin
						cur_q <= nxt;
						src_q <= SRC_RAM;
						lvl_q <= lvl_q + 1'b1;
						addr_q <= addr_q << 1;
					end else if (pool_full) begin
						state_q <= S_IDLE;
						res_q <= '{valid: 1'b1, domain: '0, matched: 1'b0,
							status: btpm_pkg::ST_POOL_FULL};
					end else begin
						// The new node is held as fresh until it is written on the next step.
						cur_q <= free_q[btpm_pkg::IDX_W-1:0];
						src_q <= SRC_FRESH;
						free_q <= free_q + 1'b1;
						lvl_q <= lvl_q + 1'b1;
						addr_q <= addr_q << 1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.valid |-> state_q == S_IDLE)
		else $error("result strobe while a walk is still running");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q != '0 && free_q <= btpm_pkg::POOL_END)
		else $error("free node counter out of range");

	a_write_add: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == S_ADD && src_q != SRC_ROOT)
		else $error("node memory written outside an add");

	a_look_depth: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOOK |-> lvl_q <= btpm_pkg::LEVELS)
		else $error("lookup walked past the last address bit");

	a_match_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.valid && res_q.matched |-> res_q.status == btpm_pkg::ST_OK)
		else $error("match reported with an error status");

endmodule

/* sv/binary_trie_prefix_match.sv */
// Longest prefix match over a unibit binary trie of IPv4 prefixes.
// A word is taken at a rising edge with start high and busy low. func selects
// lookup, add or clear; address, prefix_len and domain_in go with it.
// Every word gives exactly one result: done is high for one cycle with
// domain_out, matched and status, and the receiver cannot hold it off.
// A lookup visits at most 33 trie levels, the root included; an add walks down
// to level prefix_len, or stops early if the node pool is full. Each level
// below the root, but a freshly added one, is one read of the node memory,
// whose registered read data feeds the next read address, so that read port
// sets the pace. done rises in the same cycle that busy falls, and a new word
// may be started in that cycle. Clear, an add with a bad length and an unused
// func are answered in the next cycle without busy. cfg_wr_en writes the
// no-match domain; the user must do so only while idle (not enforced by the
// block). Reset empties the trie at once (root in flip-flops, allocation
// restarts at node 1) with no memory sweep; no-match domain resets to 65535.
module binary_trie_prefix_match (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           func,
	input  logic [btpm_pkg::ADDR_W-1:0]          address,
	input  logic [btpm_pkg::LEN_W-1:0]           prefix_len,
	input  logic [btpm_pkg::DOM_W-1:0]           domain_in,
	output logic                                 done,
	output logic [btpm_pkg::DOM_W-1:0]           domain_out,
	output logic                                 matched,
	output logic [1:0]                           status,
	input  logic                                 cfg_wr_en,
	input  logic [btpm_pkg::DOM_W-1:0]           cfg_wr_data
);

	logic [btpm_pkg::DOM_W-1:0] no_match_q;
	btpm_pkg::result_t result;
	logic ram_we;
	logic [btpm_pkg::IDX_W-1:0] ram_waddr;
	logic [btpm_pkg::IDX_W-1:0] ram_raddr;
	btpm_pkg::node_t ram_wdata;
	btpm_pkg::node_t ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_match_q <= '1;
		end else if (cfg_wr_en) begin
			no_match_q <= cfg_wr_data;
		end
	end

	btpm_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.address    (address),
		.prefix_len (prefix_len),
		.domain_in  (domain_in),
		.no_match   (no_match_q),
		.result     (result),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	btpm_ram #(
		.WIDTH (btpm_pkg::NODE_W),
		.DEPTH (btpm_pkg::NODE_COUNT)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign done = result.valid;
	assign domain_out = result.domain;
	assign matched = result.matched;
	assign status = result.status;

endmodule
